// ===== sv/qrs_pkg.sv =====
// qrs_pkg: types, codes and shared helpers of the quadtree range sampler.
// Has no dependencies. quadtree_range_sampler and qrs_mod_unit refer to it by scoped names.

package qrs_pkg;

   // Field widths of the request and response items
   localparam int COORD_W  = 17;
   localparam int ID_W     = 10;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int SEED_W   = 32;

   // One unit of the square in fixed point
   localparam logic [COORD_W-1:0] ROOT_SPAN = COORD_W'(65536);

   // Defaults for the top level parameters
   localparam int TREE_DEPTH_DEF    = 5;
   localparam int MAX_POINTS_DEF    = 1024;
   localparam int LEAF_CAPACITY_DEF = 16;

   // Draw generator value after reset
   localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SAMPLE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_ABSENT    = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type            command;
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
      logic [ID_W-1:0]    point_id;
      logic [COORD_W-1:0] range_x_min;
      logic [COORD_W-1:0] range_y_min;
      logic [COORD_W-1:0] range_x_max;
      logic [COORD_W-1:0] range_y_max;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [COORD_W-1:0] sampled_x;
      logic [COORD_W-1:0] sampled_y;
      logic [ID_W-1:0]    sampled_id;
   } rsp_type;

   // Step the xorshift32 draw generator once
   function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] t;
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage

// ===== sv/quadtree_range_sampler.sv =====
// quadtree_range_sampler: fixed-depth quadtree with weighted range sampling.
// Depends on qrs_pkg, qrs_ram and qrs_mod_unit.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  qrs_pkg::req_type
//   rsp       out        rsp_valid/rsp_stall  qrs_pkg::rsp_type
//   csr       in         csr_wen              csr_wdata, loads the draw generator
//
// One request at a time. Insert and remove make one node-count RAM access per tree
// level, read then write. Sample makes two walks over the tree, plus up to
// TREE_DEPTH+2 draws in the bit-serial remainder unit. After reset a clearing
// pass over max(node count, MAX_POINTS) addresses (1365 by default) wipes node
// counts and point valid flags; req_stall stays high. A finished response waits
// in the output register; a new request is taken meanwhile, and the block holds
// its next response until the slot is free.

module quadtree_range_sampler #(
   parameter int TREE_DEPTH    = qrs_pkg::TREE_DEPTH_DEF,
   parameter int MAX_POINTS    = qrs_pkg::MAX_POINTS_DEF,
   parameter int LEAF_CAPACITY = qrs_pkg::LEAF_CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  qrs_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output qrs_pkg::rsp_type           rsp_payload,
   input  logic                       csr_wen,
   input  logic [qrs_pkg::SEED_W-1:0] csr_wdata
);

   localparam int LEAF_TOTAL = 1 << (2 * TREE_DEPTH);
   localparam int LEAF_FIRST = (LEAF_TOTAL - 1) / 3;
   localparam int NODE_TOTAL = (4 * LEAF_TOTAL - 1) / 3;
   localparam int NODE_W     = $clog2(NODE_TOTAL);
   localparam int DEPTH_W    = $clog2(TREE_DEPTH + 1);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int REC_AW     = $clog2(MAX_POINTS);
   localparam int SLOT_W     = (LEAF_CAPACITY > 1) ? $clog2(LEAF_CAPACITY) : 1;
   localparam int SLOT_TOTAL = LEAF_TOTAL * LEAF_CAPACITY;
   localparam int SLOT_AW    = $clog2(SLOT_TOTAL);
   localparam int CLR_TOTAL  = (NODE_TOTAL > MAX_POINTS) ? NODE_TOTAL : MAX_POINTS;
   localparam int CLR_W      = $clog2(CLR_TOTAL + 1);
   localparam int COORD_W    = qrs_pkg::COORD_W;
   localparam int ID_W       = qrs_pkg::ID_W;
   localparam int SEED_W     = qrs_pkg::SEED_W;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_REC_RD, S_REC_CHK, S_PATH, S_LEAF_CHK, S_MV_RD, S_MV_WR,
      S_UPD_RD, S_UPD_WR, S_WALK_VIS, S_WALK_ACC, S_WALK_ADV, S_DESC_RD, S_DESC_CNT,
      S_CH_RD, S_CH_CHK, S_SLOT_RD, S_SLOT_ID, S_POS, S_DRAW, S_DONE
   } state_type;

   // Registers
   state_type          state_ff, state_in;
   state_type          ret_ff, ret_in;
   qrs_pkg::req_type   req_ff, req_in;
   logic [COORD_W-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [COORD_W-1:0] x0_ff, x0_in, y0_ff, y0_in, span_ff, span_in;
   logic               pass_ff, pass_in;
   logic [CNT_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   tgt_ff, tgt_in;
   logic [1:0]         ch_ff, ch_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]   leaf_cnt_ff, leaf_cnt_in;
   logic [ID_W-1:0]    id_ff, id_in;
   qrs_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   qrs_pkg::rsp_type   rsp_ff, rsp_in;
   logic [SEED_W-1:0]  draw_ff, draw_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;

   // RAM ports
   logic                 cnt_we;
   logic [NODE_W-1:0]    cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]     cnt_wdata, cnt_rdata;
   logic                 vld_we;
   logic [REC_AW-1:0]    vld_waddr, rec_raddr;
   logic                 vld_wdata, vld_rdata;
   logic                 pos_we;
   logic [2*COORD_W-1:0] pos_wdata, pos_rdata;
   logic                 rsl_we;
   logic [REC_AW-1:0]    rsl_waddr;
   logic [SLOT_W-1:0]    rsl_wdata, rsl_rdata;
   logic                 mem_we;
   logic [SLOT_AW-1:0]   mem_waddr, mem_raddr;
   logic [ID_W-1:0]      mem_wdata, mem_rdata;

   // Remainder unit
   logic                 mod_start;
   logic [CNT_W-1:0]     mod_div;
   logic                 mod_done;
   logic [CNT_W-1:0]     mod_rem;
   logic [SEED_W-1:0]    draw_next;

   // Geometry and addressing helpers
   logic [COORD_W-1:0] x1, y1, half, xm, ym;
   logic               isect, contain, cx, cy;
   logic [NODE_W-1:0]  nm1, path_child, pick_child, leaf_off;
   logic [1:0]         sib_c;
   logic [SLOT_AW-1:0] slot_base;
   logic               id_big, slot_id_big;

   function automatic logic [NODE_W-1:0] child_of(input logic [NODE_W-1:0] n,
                                                  input logic [1:0] c);
      return NODE_W'({n, 2'b00} + (NODE_W + 2)'(c) + (NODE_W + 2)'(1));
   endfunction

   assign draw_next = qrs_pkg::xorshift32(draw_ff);

   // Node box, query tests, and path step towards the stored point
   always_comb begin
      x1         = x0_ff + span_ff;
      y1         = y0_ff + span_ff;
      isect      = !(x0_ff > req_ff.range_x_max || x1 < req_ff.range_x_min ||
                     y0_ff > req_ff.range_y_max || y1 < req_ff.range_y_min);
      contain    = x0_ff >= req_ff.range_x_min && x1 <= req_ff.range_x_max &&
                   y0_ff >= req_ff.range_y_min && y1 <= req_ff.range_y_max;
      half       = span_ff >> 1;
      xm         = x0_ff + half;
      ym         = y0_ff + half;
      cx         = pt_x_ff > xm;
      cy         = pt_y_ff > ym;
      path_child = child_of(node_ff, {cy, cx});
      pick_child = child_of(node_ff, ch_ff);
      nm1        = node_ff - NODE_W'(1);
      sib_c      = nm1[1:0];
      leaf_off   = node_ff - NODE_W'(LEAF_FIRST);
      slot_base  = SLOT_AW'(SLOT_AW'(leaf_off) * SLOT_AW'(LEAF_CAPACITY));
      id_big     = 32'(req_ff.point_id) >= MAX_POINTS;
      slot_id_big = 32'(mem_rdata) >= MAX_POINTS;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      req_in       = req_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      span_in      = span_ff;
      pass_in      = pass_ff;
      sum_in       = sum_ff;
      tgt_in       = tgt_ff;
      ch_in        = ch_ff;
      slot_in      = slot_ff;
      leaf_cnt_in  = leaf_cnt_ff;
      id_in        = id_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      draw_in      = draw_ff;
      clr_in       = clr_ff;

      cnt_we    = 1'b0;
      cnt_waddr = node_ff;
      cnt_wdata = '0;
      cnt_raddr = (state_ff == S_CH_RD) ? pick_child : node_ff;
      vld_we    = 1'b0;
      vld_waddr = REC_AW'(req_ff.point_id);
      vld_wdata = 1'b0;
      rec_raddr = (state_ff == S_SLOT_ID) ? REC_AW'(mem_rdata)
                                          : REC_AW'(req_ff.point_id);
      pos_we    = 1'b0;
      pos_wdata = {pt_x_ff, pt_y_ff};
      rsl_we    = 1'b0;
      rsl_waddr = REC_AW'(req_ff.point_id);
      rsl_wdata = '0;
      mem_we    = 1'b0;
      mem_waddr = slot_base;
      mem_wdata = req_ff.point_id;
      mem_raddr = (state_ff == S_SLOT_RD) ? slot_base + SLOT_AW'(tgt_ff)
                                          : slot_base + SLOT_AW'(leaf_cnt_ff - CNT_W'(1));
      mod_start = 1'b0;
      mod_div   = '0;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            cnt_we    = 32'(clr_ff) < NODE_TOTAL;
            cnt_waddr = NODE_W'(clr_ff);
            vld_we    = 32'(clr_ff) < MAX_POINTS;
            vld_waddr = REC_AW'(clr_ff);
            clr_in    = clr_ff + CLR_W'(1);
            if (32'(clr_ff) == CLR_TOTAL - 1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               pt_x_in  = req_payload.x_coord;
               pt_y_in  = req_payload.y_coord;
               res_in   = '0;
               node_in  = '0;
               depth_in = '0;
               x0_in    = '0;
               y0_in    = '0;
               span_in  = qrs_pkg::ROOT_SPAN;
               pass_in  = 1'b0;
               sum_in   = '0;
               priority case (req_payload.command)
                  qrs_pkg::CMD_INSERT: state_in = S_REC_RD;
                  qrs_pkg::CMD_REMOVE: state_in = S_REC_RD;
                  qrs_pkg::CMD_SAMPLE: state_in = S_WALK_VIS;
                  default:             state_in = S_DONE;
               endcase
            end
         end

         S_REC_RD: begin
            state_in = S_REC_CHK;
         end

         // Check the point record before touching the tree
         S_REC_CHK: begin
            if (req_ff.command == qrs_pkg::CMD_INSERT) begin
               if (id_big) begin
                  res_in.status = qrs_pkg::ST_FULL;
                  state_in      = S_DONE;
               end else if (vld_rdata) begin
                  res_in.status = qrs_pkg::ST_DUPLICATE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_PATH;
               end
            end else begin
               if (id_big || !vld_rdata) begin
                  res_in.status = qrs_pkg::ST_ABSENT;
                  state_in      = S_DONE;
               end else begin
                  pt_x_in  = pos_rdata[2*COORD_W-1:COORD_W];
                  pt_y_in  = pos_rdata[COORD_W-1:0];
                  slot_in  = rsl_rdata;
                  state_in = S_PATH;
               end
            end
         end

         // Descend one level a cycle to the point's leaf
         S_PATH: begin
            if (depth_ff == DEPTH_W'(TREE_DEPTH)) begin
               state_in = S_LEAF_CHK;
            end else begin
               node_in  = path_child;
               depth_in = depth_ff + DEPTH_W'(1);
               x0_in    = cx ? xm : x0_ff;
               y0_in    = cy ? ym : y0_ff;
               span_in  = half;
            end
         end

         S_LEAF_CHK: begin
            leaf_cnt_in = cnt_rdata;
            if (req_ff.command == qrs_pkg::CMD_INSERT) begin
               if (32'(cnt_rdata) >= LEAF_CAPACITY) begin
                  res_in.status = qrs_pkg::ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  // Commit the new point to its slot and record
                  mem_we    = 1'b1;
                  mem_waddr = slot_base + SLOT_AW'(cnt_rdata);
                  pos_we    = 1'b1;
                  rsl_we    = 1'b1;
                  rsl_wdata = SLOT_W'(cnt_rdata);
                  vld_we    = 1'b1;
                  vld_wdata = 1'b1;
                  node_in   = '0;
                  depth_in  = '0;
                  x0_in     = '0;
                  y0_in     = '0;
                  span_in   = qrs_pkg::ROOT_SPAN;
                  state_in  = S_UPD_RD;
               end
            end else begin
               state_in = S_MV_RD;
            end
         end

         S_MV_RD: begin
            state_in = S_MV_WR;
         end

         // Fill the hole with the leaf's last member and drop the point
         S_MV_WR: begin
            mem_we    = 1'b1;
            mem_waddr = slot_base + SLOT_AW'(slot_ff);
            mem_wdata = mem_rdata;
            rsl_we    = 1'b1;
            rsl_waddr = REC_AW'(mem_rdata);
            rsl_wdata = slot_ff;
            vld_we    = 1'b1;
            vld_wdata = 1'b0;
            node_in   = '0;
            depth_in  = '0;
            x0_in     = '0;
            y0_in     = '0;
            span_in   = qrs_pkg::ROOT_SPAN;
            state_in  = S_UPD_RD;
         end

         S_UPD_RD: begin
            state_in = S_UPD_WR;
         end

         // Update the count of this path node, then step down or finish at the leaf
         S_UPD_WR: begin
            cnt_we = 1'b1;
            if (req_ff.command == qrs_pkg::CMD_INSERT) begin
               cnt_wdata = cnt_rdata + CNT_W'(1);
            end else begin
               cnt_wdata = cnt_rdata - CNT_W'(1);
            end
            if (depth_ff == DEPTH_W'(TREE_DEPTH)) begin
               state_in = S_DONE;
            end else begin
               node_in  = path_child;
               depth_in = depth_ff + DEPTH_W'(1);
               x0_in    = cx ? xm : x0_ff;
               y0_in    = cy ? ym : y0_ff;
               span_in  = half;
               state_in = S_UPD_RD;
            end
         end

         // Range walk: visit a node
         S_WALK_VIS: begin
            if (!isect) begin
               state_in = S_WALK_ADV;
            end else if (depth_ff == DEPTH_W'(TREE_DEPTH) || contain) begin
               state_in = S_WALK_ACC;
            end else begin
               node_in  = child_of(node_ff, 2'd0);
               depth_in = depth_ff + DEPTH_W'(1);
               span_in  = half;
            end
         end

         // Range walk: sum terminal counts, or seek the drawn one
         S_WALK_ACC: begin
            if (!pass_ff) begin
               sum_in   = sum_ff + cnt_rdata;
               state_in = S_WALK_ADV;
            end else if (tgt_ff < cnt_rdata) begin
               state_in = S_DESC_RD;
            end else begin
               tgt_in   = tgt_ff - cnt_rdata;
               state_in = S_WALK_ADV;
            end
         end

         // Range walk: move to the next sibling or climb; at the root, draw or end empty
         S_WALK_ADV: begin
            if (depth_ff == '0) begin
               if (pass_ff || sum_ff == '0) begin
                  res_in.status = qrs_pkg::ST_EMPTY;
                  state_in      = S_DONE;
               end else begin
                  mod_start = 1'b1;
                  mod_div   = sum_ff;
                  draw_in   = draw_next;
                  pass_in   = 1'b1;
                  ret_in    = S_WALK_VIS;
                  state_in  = S_DRAW;
               end
            end else if (sib_c == 2'd3) begin
               node_in  = NODE_W'(nm1 >> 2);
               depth_in = depth_ff - DEPTH_W'(1);
               x0_in    = x0_ff - span_ff;
               y0_in    = y0_ff - span_ff;
               span_in  = span_ff << 1;
            end else begin
               node_in  = node_ff + NODE_W'(1);
               state_in = S_WALK_VIS;
               unique case (sib_c)
                  2'd1: begin
                     x0_in = x0_ff - span_ff;
                     y0_in = y0_ff + span_ff;
                  end
                  default: x0_in = x0_ff + span_ff;
               endcase
            end
         end

         S_DESC_RD: begin
            state_in = S_DESC_CNT;
         end

         // Draw within this node's count
         S_DESC_CNT: begin
            leaf_cnt_in = cnt_rdata;
            if (cnt_rdata == '0 || (depth_ff == DEPTH_W'(TREE_DEPTH) &&
                                    32'(cnt_rdata) > LEAF_CAPACITY)) begin
               res_in.status = qrs_pkg::ST_EMPTY;
               state_in      = S_DONE;
            end else begin
               mod_start = 1'b1;
               mod_div   = cnt_rdata;
               draw_in   = draw_next;
               ch_in     = 2'd0;
               ret_in    = (depth_ff == DEPTH_W'(TREE_DEPTH)) ? S_SLOT_RD : S_CH_RD;
               state_in  = S_DRAW;
            end
         end

         S_CH_RD: begin
            state_in = S_CH_CHK;
         end

         // Pick the child whose count covers the draw
         S_CH_CHK: begin
            if (tgt_ff < cnt_rdata || ch_ff == 2'd3) begin
               node_in  = pick_child;
               depth_in = depth_ff + DEPTH_W'(1);
               state_in = S_DESC_RD;
            end else begin
               tgt_in   = tgt_ff - cnt_rdata;
               ch_in    = ch_ff + 2'd1;
               state_in = S_CH_RD;
            end
         end

         S_SLOT_RD: begin
            state_in = S_SLOT_ID;
         end

         S_SLOT_ID: begin
            id_in = mem_rdata;
            if (slot_id_big) begin
               res_in.status = qrs_pkg::ST_EMPTY;
               state_in      = S_DONE;
            end else begin
               state_in = S_POS;
            end
         end

         S_POS: begin
            res_in.status     = qrs_pkg::ST_OK;
            res_in.sampled_x  = pos_rdata[2*COORD_W-1:COORD_W];
            res_in.sampled_y  = pos_rdata[COORD_W-1:0];
            res_in.sampled_id = id_ff;
            state_in          = S_DONE;
         end

         S_DRAW: begin
            if (mod_done) begin
               tgt_in   = mod_rem;
               node_in  = (ret_ff == S_WALK_VIS) ? '0 : node_ff;
               depth_in = (ret_ff == S_WALK_VIS) ? '0 : depth_ff;
               state_in = ret_ff;
            end
         end

         // Hand over the response once the output slot is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Load the draw generator on a register write
      if (csr_wen) begin
         draw_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         draw_ff      <= qrs_pkg::SEED_RESET;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         draw_ff      <= draw_in;
         clr_ff       <= clr_in;
      end
      req_ff      <= req_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      node_ff     <= node_in;
      depth_ff    <= depth_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      span_ff     <= span_in;
      pass_ff     <= pass_in;
      sum_ff      <= sum_in;
      tgt_ff      <= tgt_in;
      ch_ff       <= ch_in;
      slot_ff     <= slot_in;
      leaf_cnt_ff <= leaf_cnt_in;
      id_ff       <= id_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Stores
   qrs_ram #(.WIDTH(CNT_W), .DEPTH(NODE_TOTAL), .ADDR_W(NODE_W)) u_node_counts (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   qrs_ram #(.WIDTH(1), .DEPTH(MAX_POINTS), .ADDR_W(REC_AW)) u_rec_valid (
      .clock(clock), .wr_en(vld_we), .wr_addr(vld_waddr), .wr_data(vld_wdata),
      .rd_addr(rec_raddr), .rd_data(vld_rdata)
   );

   qrs_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS), .ADDR_W(REC_AW)) u_rec_pos (
      .clock(clock), .wr_en(pos_we), .wr_addr(REC_AW'(req_ff.point_id)),
      .wr_data(pos_wdata), .rd_addr(rec_raddr), .rd_data(pos_rdata)
   );

   qrs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_POINTS), .ADDR_W(REC_AW)) u_rec_slot (
      .clock(clock), .wr_en(rsl_we), .wr_addr(rsl_waddr), .wr_data(rsl_wdata),
      .rd_addr(rec_raddr), .rd_data(rsl_rdata)
   );

   qrs_ram #(.WIDTH(ID_W), .DEPTH(SLOT_TOTAL), .ADDR_W(SLOT_AW)) u_leaf_slots (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata)
   );

   qrs_mod_unit #(.DIV_W(CNT_W)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(draw_next),
      .divisor(mod_div), .done(mod_done), .remainder(mod_rem)
   );

   // A failed request carries no sampled point
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != qrs_pkg::ST_OK |->
      rsp_ff.sampled_x == '0 && rsp_ff.sampled_y == '0 && rsp_ff.sampled_id == '0)
      else $error("failed response carries a point");

   // One request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // No response before the clearing pass ends
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("response during clearing pass");

endmodule

// ===== sv/qrs_ram.sv =====
// qrs_ram: generic single write port, single read port RAM with registered read.
// No dependencies; instanced for every store of the sampler.

module qrs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/qrs_mod_unit.sv =====
// qrs_mod_unit: bit-serial remainder of a draw word by a count, one bit a cycle.
// Depends on qrs_pkg for the draw word width.

module qrs_mod_unit #(
   parameter int DIV_W = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [qrs_pkg::SEED_W-1:0] dividend,
   input  logic [DIV_W-1:0]          divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          remainder
);

   localparam int STEP_W = $clog2(qrs_pkg::SEED_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [qrs_pkg::SEED_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]           div_ff, div_in;
   logic [DIV_W-1:0]           rem_ff, rem_in;
   logic [DIV_W:0]             trial;
   logic [DIV_W-1:0]           rem_step;

   // Restoring step: shift in one dividend bit, subtract where it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[qrs_pkg::SEED_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_step = DIV_W'(trial - {1'b0, div_ff});
      end else begin
         rem_step = trial[DIV_W-1:0];
      end
   end

   // Advance the iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(qrs_pkg::SEED_W - 1);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_step;
         dvd_in  = dvd_ff << 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== bench/quadtree_range_sampler_test.sv =====
// Self-checking bench for quadtree_range_sampler: directed and random insert, remove and
// sample requests are predicted by an in-bench quadtree model and checked on every response.
// Depends on qrs_pkg and the quadtree_range_sampler RTL.

module quadtree_range_sampler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 5;
   localparam int NPOINTS   = 1024;
   localparam int LEAF_CAP  = 16;
   localparam int NLEAVES   = 1 << (2 * DEPTH);
   localparam int LEAF_BASE = (NLEAVES - 1) / 3;
   localparam int NNODES    = (4 * NLEAVES - 1) / 3;
   localparam int SPAN      = 65536;
   localparam int IDLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   qrs_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   qrs_pkg::rsp_type rsp_payload;
   logic csr_wen = 1'b0;
   logic [qrs_pkg::SEED_W-1:0] csr_wdata = '0;

   quadtree_range_sampler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   int unsigned tree_count [NNODES];
   logic [16:0] pt_x [NPOINTS];
   logic [16:0] pt_y [NPOINTS];
   int unsigned pt_slot [NPOINTS];
   bit          pt_live [NPOINTS];
   int unsigned leaf_member [NLEAVES * LEAF_CAP];
   logic [31:0] gen_state;
   int unsigned box_x0, box_y0, box_x1, box_y1;
   int unsigned hit_total, hit_target, hit_node, hit_level;
   bit          hit_found;

   qrs_pkg::req_type pending_reqs[$];
   qrs_pkg::rsp_type expected_rsps[$];
   int mismatches = 0, sent = 0, answered = 0, samples_ok = 0, idle_cycles = 0;
   bit timed_out = 0;

   function automatic int unsigned next_draw(int unsigned n);
      gen_state = gen_state ^ (gen_state << 13);
      gen_state = gen_state ^ (gen_state >> 17);
      gen_state = gen_state ^ (gen_state << 5);
      return (n != 0) ? gen_state % n : 0;
   endfunction

   function automatic int unsigned leaf_of(int unsigned x, int unsigned y);
      int unsigned node, x0, y0, x1, y1, xm, ym, c;
      node = 0; x0 = 0; y0 = 0; x1 = SPAN; y1 = SPAN;
      for (int d = 1; d <= DEPTH; d++) begin
         xm = (x0 + x1) >> 1; ym = (y0 + y1) >> 1; c = 0;
         if (x > xm) begin c |= 1; x0 = xm; end else x1 = xm;
         if (y > ym) begin c |= 2; y0 = ym; end else y1 = ym;
         node = 4 * node + 1 + c;
      end
      return node;
   endfunction

   // bump counts on the root-to-leaf path
   function automatic void adjust_path(int unsigned leaf, int delta);
      int unsigned node;
      node = leaf;
      for (int d = DEPTH; d >= 0; d--) begin
         tree_count[node] = tree_count[node] + delta;
         if (d > 0) node = (node - 1) / 4;
      end
   endfunction

   function automatic void range_walk(int unsigned node, int unsigned lvl, int unsigned x0,
                                      int unsigned y0, int unsigned x1, int unsigned y1,
                                      bit seek);
      int unsigned xm, ym, c;
      if (x0 > box_x1 || x1 < box_x0 || y0 > box_y1 || y1 < box_y0) return;
      if (lvl == DEPTH || (x0 >= box_x0 && x1 <= box_x1 && y0 >= box_y0 && y1 <= box_y1))
      begin
         c = tree_count[node];
         if (!seek) hit_total += c;
         else if (!hit_found) begin
            if (hit_target < c) begin
               hit_found = 1; hit_node = node; hit_level = lvl;
            end else hit_target -= c;
         end
         return;
      end
      xm = (x0 + x1) >> 1; ym = (y0 + y1) >> 1;
      range_walk(4*node+1, lvl+1, x0, y0, xm, ym, seek);
      range_walk(4*node+2, lvl+1, xm, y0, x1, ym, seek);
      range_walk(4*node+3, lvl+1, x0, ym, xm, y1, seek);
      range_walk(4*node+4, lvl+1, xm, ym, x1, y1, seek);
   endfunction

   function automatic qrs_pkg::rsp_type predict_quadtree(qrs_pkg::req_type r);
      qrs_pkg::rsp_type o;
      int unsigned leaf, cnt, base, last, slot, moved, node, lvl, pick, rr, id;
      o = '0; o.status = qrs_pkg::ST_OK;
      case (r.command)
         qrs_pkg::CMD_INSERT: begin
            id = r.point_id;
            if (pt_live[id]) o.status = qrs_pkg::ST_DUPLICATE;
            else begin
               leaf = leaf_of(r.x_coord, r.y_coord);
               cnt = tree_count[leaf];
               if (cnt >= LEAF_CAP) o.status = qrs_pkg::ST_FULL;
               else begin
                  adjust_path(leaf, 1);
                  leaf_member[(leaf - LEAF_BASE) * LEAF_CAP + cnt] = id;
                  pt_x[id] = r.x_coord; pt_y[id] = r.y_coord;
                  pt_slot[id] = cnt; pt_live[id] = 1;
               end
            end
         end
         qrs_pkg::CMD_REMOVE: begin
            id = r.point_id;
            if (!pt_live[id]) o.status = qrs_pkg::ST_ABSENT;
            else begin
               leaf = leaf_of(pt_x[id], pt_y[id]);
               base = (leaf - LEAF_BASE) * LEAF_CAP;
               last = tree_count[leaf] - 1;
               slot = pt_slot[id];
               moved = leaf_member[base + last];
               leaf_member[base + slot] = moved;
               pt_slot[moved] = slot;
               adjust_path(leaf, -1);
               pt_live[id] = 0;
            end
         end
         qrs_pkg::CMD_SAMPLE: begin
            box_x0 = r.range_x_min; box_y0 = r.range_y_min;
            box_x1 = r.range_x_max; box_y1 = r.range_y_max;
            hit_total = 0;
            range_walk(0, 0, 0, 0, SPAN, SPAN, 0);
            if (hit_total == 0) o.status = qrs_pkg::ST_EMPTY;
            else begin
               hit_target = next_draw(hit_total);
               hit_found = 0;
               range_walk(0, 0, 0, 0, SPAN, SPAN, 1);
               node = hit_node; lvl = hit_level;
               // descend by child counts
               while (lvl < DEPTH) begin
                  rr = next_draw(tree_count[node]);
                  pick = 4 * node + 4;
                  for (int c = 0; c < 4; c++) begin
                     if (rr < tree_count[4*node+1+c]) begin
                        pick = 4*node+1+c; break;
                     end
                     rr -= tree_count[4*node+1+c];
                  end
                  node = pick; lvl++;
               end
               rr = next_draw(tree_count[node]);
               id = leaf_member[(node - LEAF_BASE) * LEAF_CAP + rr];
               o.sampled_x = pt_x[id]; o.sampled_y = pt_y[id]; o.sampled_id = 10'(id);
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [16:0] rand_coord();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 17'(SPAN);
      if (p == 1) return 17'h1FFFF - 17'($urandom_range(0, 3));
      if (p == 2) return 17'(32768 >> $urandom_range(0, 5));
      return 17'($urandom_range(0, SPAN - 1));
   endfunction

   // driver: present queued requests with random gaps
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps = {expected_rsps, predict_quadtree(req_payload)};
            sent++;
         end
         if (req_valid && req_stall) begin
            // hold
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && (!req_valid || !req_stall)) begin
            req_payload <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            send_gap <= gap_length();
         end else req_valid <= 1'b0;
      end
   end

   // monitor: check responses, apply random back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            answered++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_payload);
            end else begin
               qrs_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e.status == qrs_pkg::ST_OK && rsp_payload.status == qrs_pkg::ST_OK &&
                   e.sampled_id != 0)
                  samples_ok++;
               if (rsp_payload.status !== e.status || rsp_payload.sampled_x !== e.sampled_x
                   || rsp_payload.sampled_y !== e.sampled_y
                   || rsp_payload.sampled_id !== e.sampled_id) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", e, rsp_payload);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_left <= gap_length();
            rsp_stall <= ($urandom_range(0, 1) == 1);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_request(qrs_pkg::cmd_type c, logic [16:0] x, logic [16:0] y,
                              logic [9:0] id, logic [16:0] a, logic [16:0] b,
                              logic [16:0] cc, logic [16:0] d);
      qrs_pkg::req_type r;
      r.command = c; r.x_coord = x; r.y_coord = y; r.point_id = id;
      r.range_x_min = a; r.range_y_min = b; r.range_x_max = cc; r.range_y_max = d;
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic add_random(int k);
      int p;
      logic [16:0] a, b;
      repeat (k) begin
         p = $urandom_range(0, 99);
         a = rand_coord(); b = rand_coord();
         if (p < 45)
            add_request(qrs_pkg::CMD_INSERT, rand_coord(), rand_coord(),
                        10'($urandom_range(0, 1023)),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
         else if (p < 65)
            add_request(qrs_pkg::CMD_REMOVE, rand_coord(), rand_coord(),
                        10'($urandom_range(0, 1023)),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
         else if (p < 90)
            add_request(qrs_pkg::CMD_SAMPLE, rand_coord(), rand_coord(), 10'($urandom),
                        (a < b) ? a : b, rand_coord(), (a < b) ? b : a, 17'h1FFFF);
         else
            add_request(qrs_pkg::CMD_SAMPLE, rand_coord(), rand_coord(), 10'($urandom),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   // wait for all responses, let the block settle, then load a new seed
   task automatic drain_and_seed(logic [31:0] seed);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wen <= 1'b1; csr_wdata <= seed;
      @(posedge clock);
      csr_wen <= 1'b0;
      gen_state = seed;
   endtask

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NNODES; i++) tree_count[i] = 0;
      for (int i = 0; i < NPOINTS; i++) begin
         pt_live[i] = 0; pt_x[i] = 0; pt_y[i] = 0; pt_slot[i] = 0;
      end
      for (int i = 0; i < NLEAVES * LEAF_CAP; i++) leaf_member[i] = 0;
      gen_state = qrs_pkg::SEED_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, duplicates, absent, full leaf, empty and inverted boxes
      add_request(qrs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 17'(SPAN), 17'(SPAN));
      add_request(qrs_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 0, 0);
      add_request(qrs_pkg::CMD_INSERT, 17'(SPAN), 17'(SPAN), 10'd1023, 0, 0, 0, 0);
      add_request(qrs_pkg::CMD_INSERT, 17'h1FFFF, 17'h1FFFF, 10'd5, 0, 0, 0, 0);
      add_request(qrs_pkg::CMD_INSERT, 17'd32768, 17'd32768, 10'd6, 0, 0, 0, 0);
      add_request(qrs_pkg::CMD_INSERT, 1, 1, 10'd0, 0, 0, 0, 0);
      add_request(qrs_pkg::CMD_REMOVE, 0, 0, 10'd700, 0, 0, 0, 0);
      for (int i = 0; i < 17; i++)
         add_request(qrs_pkg::CMD_INSERT, 17'd100, 17'd100, 10'(100 + i), 0, 0, 0, 0);
      add_request(qrs_pkg::CMD_SAMPLE, 0, 0, 0, 17'(SPAN), 17'(SPAN), 0, 0);
      add_request(qrs_pkg::CMD_SAMPLE, 0, 0, 0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                  17'h1FFFF);
      add_request(qrs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 17'd200, 17'd200);
      add_request(qrs_pkg::CMD_REMOVE, 17'h1FFFF, 0, 10'd1023, 0, 0, 0, 0);
      add_request(qrs_pkg::CMD_SAMPLE, 0, 0, 0, 17'd40000, 17'd40000, 17'd41000,
                  17'd41000);
      add_random(400);
      drain_and_seed(32'hFFFF_FFFF);
      add_random(400);
      drain_and_seed(32'h0);
      add_random(150);
      drain_and_seed($urandom_range(1, 32'h7FFF_FFFF));
      add_random(500);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);

      $display("covered %0d requests, %0d responses, %0d successful samples, 4 seeds",
               sent, answered, samples_ok);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", mismatches,
                  expected_rsps.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/qrs_pkg.sv
sv/qrs_ram.sv
sv/qrs_mod_unit.sv
sv/quadtree_range_sampler.sv
bench/quadtree_range_sampler_test.sv
